@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define SEM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, off while reset is held
`define SEM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// what must hold on the cycle after reset is sampled
`define SEM_ASSERT_RST(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("post-reset check failed");

`endif

@@ rtl/sem_pkg.sv @@
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants, types and register codes of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
`default_nettype none

package sem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W    = 8;
  localparam int LINE_W   = 2 * PIX_W;               // {older row, newer row}
  localparam int ADDR_W   = $clog2(MAX_WIDTH);
  localparam int COL_W    = ADDR_W;
  localparam int WIDTH_W  = 12;
  localparam int HEIGHT_W = 13;
  localparam int ROW_W    = $clog2(MAX_HEIGHT + 2);
  localparam int SUM_W    = PIX_W + 2;               // 1,2,1 weighted sum
  localparam int SQ_W     = 2 * PIX_W;
  localparam int SQRT_STEPS = PIX_W;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(640);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);
  localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX   = HEIGHT_W'(MAX_HEIGHT);

  localparam logic [PIX_W-1:0] PIX_MAX   = {PIX_W{1'b1}};
  localparam logic [SQ_W-1:0]  SQ_MAX    = {SQ_W{1'b1}};
  localparam logic [PIX_W-1:0] ROOT_TOP  = PIX_W'(8'h80);

  // window control decoded at accept time
  typedef struct packed {
    logic emit;
    logic last;
    logic top0;   // top row outside the frame
    logic bot0;   // bottom row outside the frame
    logic zl;     // left column outside the frame
    logic zr;     // right column outside the frame
  } win_ctl_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [PIX_W-1:0] gh;
    logic [PIX_W-1:0] gv;
  } grad_t;

  typedef struct packed {
    logic            valid;
    logic            last;
    logic [SQ_W-1:0] sum;
  } sq_t;

endpackage

`default_nettype wire

@@ rtl/sem_in_if.sv @@
// ----------------------------------------------------------------------------
// sem_in_if
// Pixel input channel: valid/ready with pixel and flush.
// ----------------------------------------------------------------------------
`default_nettype none

interface sem_in_if;
  logic                      valid;
  logic                      ready;
  logic [sem_pkg::PIX_W-1:0] pixel;
  logic                      flush;

  modport source (output valid, output pixel, output flush, input ready);
  modport sink   (input valid, input pixel, input flush, output ready);
endinterface

`default_nettype wire

@@ rtl/sem_out_if.sv @@
// ----------------------------------------------------------------------------
// sem_out_if
// Result channel: valid/ready with magnitude and end-of-frame flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface sem_out_if;
  logic                      valid;
  logic                      ready;
  logic [sem_pkg::PIX_W-1:0] magnitude;
  logic                      last_of_frame;

  modport source (output valid, output magnitude, output last_of_frame, input ready);
  modport sink   (input valid, input magnitude, input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ rtl/sem_cfg_if.sv @@
// ----------------------------------------------------------------------------
// sem_cfg_if
// Register write channel: valid/ready with register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sem_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sem_pkg::CFG_IDX_W-1:0]  index;
  logic [sem_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sem_window.sv @@
// ----------------------------------------------------------------------------
// sem_window
// Frame position, two-row line store memory with read-modify-write, 3x3 window
// and clamped Sobel gradients.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_window (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_fire,
  input  wire logic [sem_pkg::PIX_W-1:0]     pixel,
  input  wire logic                          flush,
  input  wire logic [sem_pkg::WIDTH_W-1:0]   width,
  input  wire logic [sem_pkg::HEIGHT_W-1:0]  height,
  output sem_pkg::grad_t                     grad_o
);

  function automatic logic [sem_pkg::SUM_W-1:0] wsum(
    input logic [sem_pkg::PIX_W-1:0] a,
    input logic [sem_pkg::PIX_W-1:0] b,
    input logic [sem_pkg::PIX_W-1:0] c
  );
    wsum = {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
  endfunction

  function automatic logic [sem_pkg::PIX_W-1:0] clampdiff(
    input logic [sem_pkg::SUM_W-1:0] p,
    input logic [sem_pkg::SUM_W-1:0] n
  );
    logic [sem_pkg::SUM_W-1:0] d;
    d = p - n;
    if (p <= n) begin
      clampdiff = '0;
    end else if (d > sem_pkg::SUM_W'(sem_pkg::PIX_MAX)) begin
      clampdiff = sem_pkg::PIX_MAX;
    end else begin
      clampdiff = d[sem_pkg::PIX_W-1:0];
    end
  endfunction

  // position of the next word
  logic [sem_pkg::COL_W-1:0] col_r;
  logic [sem_pkg::ROW_W-1:0] row_r;

  // accept stage results
  logic [sem_pkg::COL_W-1:0]   col_cur;
  logic [sem_pkg::ROW_W-1:0]   row_cur;
  logic [sem_pkg::ROW_W-1:0]   hp1;
  logic                        restart;
  logic [sem_pkg::WIDTH_W-1:0] col_inc;
  logic [sem_pkg::COL_W-1:0]   col_nxt;
  logic [sem_pkg::ROW_W-1:0]   row_nxt;
  logic [sem_pkg::PIX_W-1:0]   val_nxt;
  logic                        mode_a;
  logic                        mode_b;
  sem_pkg::win_ctl_t           ctl_nxt;

  // window stage
  logic                         s1_valid_r;
  logic [sem_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [sem_pkg::PIX_W-1:0]    s1_val_r;
  sem_pkg::win_ctl_t            s1_ctl_r;

  logic [sem_pkg::LINE_W-1:0]   mem [0:sem_pkg::MAX_WIDTH-1];
  logic [sem_pkg::LINE_W-1:0]   rd_r;
  logic                         fwd_r;
  logic [sem_pkg::LINE_W-1:0]   fwd_data_r;
  logic [sem_pkg::LINE_W-1:0]   line;
  logic [sem_pkg::LINE_W-1:0]   wr_data;
  logic                         s1_fire;

  logic [sem_pkg::PIX_W-1:0]    win_r [0:8];

  logic [sem_pkg::PIX_W-1:0] lt, lm, lb, mt, mm, mb, rt, rm, rb;

  sem_pkg::grad_t grad_r;

  always_comb begin
    hp1     = row_r;
    hp1     = sem_pkg::ROW_W'(height) + sem_pkg::ROW_W'(1);
    restart = ({1'b0, col_r} >= width) || (row_r > hp1) ||
              ((row_r == hp1) && (col_r != '0));
    col_cur = restart ? '0 : col_r;
    row_cur = restart ? '0 : row_r;
    val_nxt = (flush || (row_cur >= sem_pkg::ROW_W'(height))) ? '0 : pixel;

    // previous row's last pixel is finished at column zero
    mode_a = (col_cur == '0) && (row_cur >= sem_pkg::ROW_W'(2));
    mode_b = (col_cur != '0) && (row_cur != '0);

    ctl_nxt.emit = mode_a || mode_b;
    ctl_nxt.last = (col_cur == '0) && (row_cur == hp1);
    ctl_nxt.top0 = mode_a ? (row_cur == sem_pkg::ROW_W'(2)) : (row_cur == sem_pkg::ROW_W'(1));
    ctl_nxt.bot0 = mode_a ? (row_cur == hp1) : (row_cur == sem_pkg::ROW_W'(height));
    ctl_nxt.zl   = mode_b && (col_cur == sem_pkg::COL_W'(1));
    ctl_nxt.zr   = mode_a;

    col_inc = {1'b0, col_cur} + sem_pkg::WIDTH_W'(1);
    if (row_cur == hp1) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (col_inc >= width) begin
      col_nxt = '0;
      row_nxt = row_cur + sem_pkg::ROW_W'(1);
    end else begin
      col_nxt = col_inc[sem_pkg::COL_W-1:0];
      row_nxt = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
      fwd_r      <= 1'b0;
    end else begin
      if (in_fire) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        // the word ahead writes this entry at the same edge as our read
        fwd_r <= s1_valid_r && (s1_addr_r == col_cur);
      end
      if (en) begin
        s1_valid_r <= in_fire;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_addr_r  <= col_cur;
      s1_val_r   <= val_nxt;
      s1_ctl_r   <= ctl_nxt;
      fwd_data_r <= wr_data;
    end
  end

  // line store: read at accept, written back from the window stage
  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_r <= mem[col_cur];
    end
    if (s1_fire) begin
      mem[s1_addr_r] <= wr_data;
    end
  end

  always_comb begin
    s1_fire = s1_valid_r && en;
    line    = fwd_r ? fwd_data_r : rd_r;
    wr_data = {line[sem_pkg::PIX_W-1:0], s1_val_r};

    lt = (s1_ctl_r.zl || s1_ctl_r.top0) ? '0 : win_r[1];
    lm = s1_ctl_r.zl ? '0 : win_r[4];
    lb = (s1_ctl_r.zl || s1_ctl_r.bot0) ? '0 : win_r[7];
    mt = s1_ctl_r.top0 ? '0 : win_r[2];
    mm = win_r[5];
    mb = s1_ctl_r.bot0 ? '0 : win_r[8];
    rt = (s1_ctl_r.zr || s1_ctl_r.top0) ? '0 : line[sem_pkg::LINE_W-1:sem_pkg::PIX_W];
    rm = s1_ctl_r.zr ? '0 : line[sem_pkg::PIX_W-1:0];
    rb = (s1_ctl_r.zr || s1_ctl_r.bot0) ? '0 : s1_val_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]     <= win_r[k*3 + 1];
        win_r[k*3 + 1] <= win_r[k*3 + 2];
      end
      win_r[2] <= line[sem_pkg::LINE_W-1:sem_pkg::PIX_W];
      win_r[5] <= line[sem_pkg::PIX_W-1:0];
      win_r[8] <= s1_val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_r.valid <= 1'b0;
    end else if (en) begin
      grad_r.valid <= s1_valid_r && s1_ctl_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grad_r.last <= s1_ctl_r.last;
      grad_r.gh   <= clampdiff(wsum(lt, mt, rt), wsum(lb, mb, rb));
      grad_r.gv   <= clampdiff(wsum(lt, lm, lb), wsum(rt, rm, rb));
    end
  end

  assign grad_o = grad_r;

endmodule

`default_nettype wire

@@ rtl/sem_square.sv @@
// ----------------------------------------------------------------------------
// sem_square
// Squares both gradients, then adds them with saturation at full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_square (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire sem_pkg::grad_t grad_i,
  output sem_pkg::sq_t        sq_o
);

  logic                     p_valid_r;
  logic                     p_last_r;
  logic [sem_pkg::SQ_W-1:0] sqh_r;
  logic [sem_pkg::SQ_W-1:0] sqv_r;
  logic [sem_pkg::SQ_W:0]   sum_nxt;
  sem_pkg::sq_t             sq_r;

  assign sum_nxt = {1'b0, sqh_r} + {1'b0, sqv_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      sq_r.valid <= 1'b0;
    end else if (en) begin
      p_valid_r  <= grad_i.valid;
      sq_r.valid <= p_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_last_r <= grad_i.last;
      sqh_r    <= {{sem_pkg::PIX_W{1'b0}}, grad_i.gh} * {{sem_pkg::PIX_W{1'b0}}, grad_i.gh};
      sqv_r    <= {{sem_pkg::PIX_W{1'b0}}, grad_i.gv} * {{sem_pkg::PIX_W{1'b0}}, grad_i.gv};
      sq_r.last <= p_last_r;
      sq_r.sum  <= sum_nxt[sem_pkg::SQ_W] ? sem_pkg::SQ_MAX : sum_nxt[sem_pkg::SQ_W-1:0];
    end
  end

  assign sq_o = sq_r;

endmodule

`default_nettype wire

@@ rtl/sem_sqrt.sv @@
// ----------------------------------------------------------------------------
// sem_sqrt
// Pipelined floor square root, one result bit per stage, most significant
// first. The last stage doubles as the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sem_sqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire sem_pkg::sq_t              sq_i,
  output logic                           valid_o,
  output logic                           last_o,
  output logic [sem_pkg::PIX_W-1:0]      root_o
);

  localparam int N = sem_pkg::SQRT_STEPS;

  logic                      vld_r  [0:N-1];
  logic                      last_r [0:N-1];
  logic [sem_pkg::PIX_W-1:0] res_r  [0:N-1];
  logic [sem_pkg::SQ_W-1:0]  v_r    [0:N-2];

  for (genvar k = 0; k < N; k++) begin : g_step
    logic                      vld_in;
    logic                      last_in;
    logic [sem_pkg::PIX_W-1:0] res_in;
    logic [sem_pkg::SQ_W-1:0]  v_in;
    logic [sem_pkg::PIX_W-1:0] trial;
    logic [sem_pkg::SQ_W-1:0]  trial_sq;

    if (k == 0) begin : g_first
      assign vld_in  = sq_i.valid;
      assign last_in = sq_i.last;
      assign res_in  = '0;
      assign v_in    = sq_i.sum;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign last_in = last_r[k-1];
      assign res_in  = res_r[k-1];
      assign v_in    = v_r[k-1];
    end

    assign trial    = res_in | (sem_pkg::ROOT_TOP >> k);
    assign trial_sq = {{sem_pkg::PIX_W{1'b0}}, trial} * {{sem_pkg::PIX_W{1'b0}}, trial};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        last_r[k] <= last_in;
        res_r[k]  <= (trial_sq <= v_in) ? trial : res_in;
      end
    end

    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          v_r[k] <= v_in;
        end
      end
    end
  end

  assign valid_o = vld_r[N-1];
  assign last_o  = last_r[N-1];
  assign root_o  = res_r[N-1];

endmodule

`default_nettype wire

@@ rtl/sobel_edge_magnitude_stream.sv @@
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream
// Streaming 3x3 Sobel edge magnitude over 8-bit grey frames.
//
// Input words carry one pixel in raster order, or a flush word that counts
// as a zero pixel; after each frame, width+1 further words (flush or not)
// drain the last row. Each result word is the magnitude of the pixel width+1
// positions back; the final pixel's word has last_of_frame set. The first
// width+1 words of a frame give no result.
// Configuration: index 0 sets frame_width, index 1 sets frame_height; values
// are clamped to 3..2048 and 3..4096. The write channel is always ready.
// Throughput: one word per cycle while the output is not stalled. Pipeline:
// the word that completes a result passes the line-store read (registered
// at the accept edge), then 1 gradient, 2 squaring and 8 square-root
// stages, the last being the output register.
// The line store is one 2048 x 16 memory, read at accept and written back from
// the window stage, with forwarding when consecutive words hit the same column.
// Reset clears position, window and pipeline; the line store is not cleared
// since rows it supplies at frame start are outside the frame anyway.
// While a result waits with out ready low, the whole pipeline holds and
// in ready drops; the output register keeps its word stable.
// ----------------------------------------------------------------------------
`default_nettype none

module sobel_edge_magnitude_stream (
  input  wire logic  clk,
  input  wire logic  rst_n,
  sem_in_if.sink     in_ch,
  sem_out_if.source  out_ch,
  sem_cfg_if.sink    cfg_ch
);

  logic [sem_pkg::WIDTH_W-1:0]  width_r;
  logic [sem_pkg::HEIGHT_W-1:0] height_r;
  logic [sem_pkg::WIDTH_W-1:0]  width_use;
  logic [sem_pkg::HEIGHT_W-1:0] height_use;

  logic           en;
  logic           in_fire;
  logic           out_valid;
  sem_pkg::grad_t grad;
  sem_pkg::sq_t   sq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= sem_pkg::WIDTH_RESET;
      height_r <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == sem_pkg::REG_FRAME_WIDTH) begin
        width_r <= cfg_ch.data[sem_pkg::WIDTH_W-1:0];
      end else if (cfg_ch.index == sem_pkg::REG_FRAME_HEIGHT) begin
        height_r <= cfg_ch.data[sem_pkg::HEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    if (width_r < sem_pkg::WIDTH_MIN) begin
      width_use = sem_pkg::WIDTH_MIN;
    end else if (width_r > sem_pkg::WIDTH_MAX) begin
      width_use = sem_pkg::WIDTH_MAX;
    end else begin
      width_use = width_r;
    end
    if (height_r < sem_pkg::HEIGHT_MIN) begin
      height_use = sem_pkg::HEIGHT_MIN;
    end else if (height_r > sem_pkg::HEIGHT_MAX) begin
      height_use = sem_pkg::HEIGHT_MAX;
    end else begin
      height_use = height_r;
    end
  end

  // pipeline moves unless the output word is stuck
  assign en           = !out_valid || out_ch.ready;
  assign in_ch.ready  = en;
  assign in_fire      = in_ch.valid && en;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid;

  sem_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_fire (in_fire),
    .pixel   (in_ch.pixel),
    .flush   (in_ch.flush),
    .width   (width_use),
    .height  (height_use),
    .grad_o  (grad)
  );

  sem_square u_square (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .grad_i (grad),
    .sq_o   (sq)
  );

  sem_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .sq_i    (sq),
    .valid_o (out_valid),
    .last_o  (out_ch.last_of_frame),
    .root_o  (out_ch.magnitude)
  );

endmodule

`default_nettype wire

@@ rtl/sem_checker.sv @@
// ----------------------------------------------------------------------------
// sem_checker
// Port-level checks on the edge magnitude stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sem_checker (
  input wire logic                      clk,
  input wire logic                      rst_n,
  input wire logic                      in_ready,
  input wire logic                      out_valid,
  input wire logic                      out_ready,
  input wire logic [sem_pkg::PIX_W-1:0] out_magnitude,
  input wire logic                      out_last
);

  logic out_stall;

  assign out_stall = out_valid && !out_ready;

  // a stalled result word holds until taken
  `SEM_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable({out_magnitude, out_last}))

  // a stalled output freezes the pipeline, so no word may enter
  `SEM_ASSERT_IMP(a_stall_blocks_in, clk, rst_n, out_stall, !in_ready)

  // with the output register empty the block always takes a word
  `SEM_ASSERT_IMP(a_empty_takes_in, clk, rst_n, !out_valid, in_ready)

  // reset leaves no result word behind
  `SEM_ASSERT_RST(a_reset_empty, clk, rst_n, !out_valid)

endmodule

bind sobel_edge_magnitude_stream sem_checker u_sem_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_magnitude (out_ch.magnitude),
  .out_last      (out_ch.last_of_frame)
);

`default_nettype wire
